// File: rtl/core/bgd_pkg.sv
package bgd_pkg;

    // field widths
    localparam int unsigned DebounceW = 10;
    localparam int unsigned HoldW     = 16;
    localparam int unsigned RampW     = 8;
    localparam int unsigned StepW     = 8;
    localparam int unsigned LevelW    = 11;
    localparam int unsigned ElapsedW  = 16;

    // apb
    localparam int unsigned AddrW = 5;
    localparam int unsigned DataW = 32;

    // register indexes
    localparam logic [2:0] RegDebounce = 3'd0;
    localparam logic [2:0] RegHold     = 3'd1;
    localparam logic [2:0] RegRamp     = 3'd2;
    localparam logic [2:0] RegStep     = 3'd3;
    localparam logic [2:0] RegMax      = 3'd4;
    localparam logic [2:0] RegMin      = 3'd5;

    // register reset values
    localparam logic [DebounceW-1:0] DebounceReset = 10'd50;
    localparam logic [HoldW-1:0]     HoldReset     = 16'd500;
    localparam logic [RampW-1:0]     RampReset     = 8'd20;
    localparam logic [StepW-1:0]     StepReset     = 8'd20;
    localparam logic [LevelW-1:0]    MaxReset      = 11'd1000;
    localparam logic [LevelW-1:0]    MinReset      = 11'd10;

    localparam logic [ElapsedW-1:0] ElapsedTop = {ElapsedW{1'b1}};

    typedef struct packed {
        logic press_event;
        logic button_level;
    } bgd_item_t;

    typedef struct packed {
        logic              lamp_on;
        logic [LevelW-1:0] pwm_level;
        logic              level_written;
    } bgd_result_t;

    typedef struct packed {
        logic [DebounceW-1:0] debounce_ticks;
        logic [HoldW-1:0]     hold_ticks;
        logic [RampW-1:0]     ramp_ticks;
        logic [StepW-1:0]     step_size;
        logic [LevelW-1:0]    max_level;
        logic [LevelW-1:0]    min_level;
    } bgd_cfg_t;

endpackage

// File: rtl/core/bgd_regs.sv
module bgd_regs
    import bgd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output bgd_cfg_t         cfg
);

    bgd_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[AddrW-1:2];
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DebounceReset;
            cfg_reg.hold_ticks     <= HoldReset;
            cfg_reg.ramp_ticks     <= RampReset;
            cfg_reg.step_size      <= StepReset;
            cfg_reg.max_level      <= MaxReset;
            cfg_reg.min_level      <= MinReset;
        end
        else if (wr_en)
        begin
            case (index)
                RegDebounce: cfg_reg.debounce_ticks <= pwdata[DebounceW-1:0];
                RegHold:     cfg_reg.hold_ticks     <= pwdata[HoldW-1:0];
                RegRamp:     cfg_reg.ramp_ticks     <= pwdata[RampW-1:0];
                RegStep:     cfg_reg.step_size      <= pwdata[StepW-1:0];
                RegMax:      cfg_reg.max_level      <= pwdata[LevelW-1:0];
                RegMin:      cfg_reg.min_level      <= pwdata[LevelW-1:0];
                default:     ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        case (index)
            RegDebounce: prdata = {{(DataW-DebounceW){1'b0}}, cfg_reg.debounce_ticks};
            RegHold:     prdata = {{(DataW-HoldW){1'b0}}, cfg_reg.hold_ticks};
            RegRamp:     prdata = {{(DataW-RampW){1'b0}}, cfg_reg.ramp_ticks};
            RegStep:     prdata = {{(DataW-StepW){1'b0}}, cfg_reg.step_size};
            RegMax:      prdata = {{(DataW-LevelW){1'b0}}, cfg_reg.max_level};
            RegMin:      prdata = {{(DataW-LevelW){1'b0}}, cfg_reg.min_level};
            default:     prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/button_gesture_dimmer.sv
// One-button lamp dimmer with click and hold gestures.
// Input channel (item_valid, item_stall, item): one item per millisecond tick,
// carrying the press edge flag and the current button level.
// Output channel (result_valid, result_stall, result): exactly one result per
// item with the lamp mode, the PWM level (0 while off) and a strobe that marks
// ticks which wrote a new level.
// Each accepted item's result is registered; throughput is one item per cycle
// while item_stall is low. The session state updates in one pass of logic
// between the state registers and the result register.
// A two-entry output buffer (result register plus skid register) lets an item
// be taken in the cycle a stalled result is still waiting; item_stall rises
// only once both entries are full and drops when the receiver takes one.
// Reset (rst_n low, asynchronous) closes any session, turns the lamp off, sets
// the level and drive level to 0, dimming upward, and loads the register
// defaults. Registers sit at APB byte address 4*i (debounce, hold, ramp, step,
// max, min); the user writes them only while the block is idle (not enforced).
module button_gesture_dimmer
    import bgd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  bgd_item_t        item,
    output logic             result_valid,
    input  logic             result_stall,
    output bgd_result_t      result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    bgd_cfg_t cfg;

    bgd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // session state
    logic                in_session_reg,  in_session_next;
    logic [ElapsedW-1:0] elapsed_reg,     elapsed_next;
    logic                mode_on_reg,     mode_on_next;
    logic [LevelW-1:0]   level_reg,       level_next;
    logic                going_down_reg,  going_down_next;
    logic [RampW-1:0]    ramp_wait_reg,   ramp_wait_next;
    logic [LevelW-1:0]   drive_level_reg, drive_level_next;
    logic                wrote;

    // output buffer
    logic        out_valid_reg;
    bgd_result_t out_data_reg;
    logic        skid_valid_reg;
    bgd_result_t skid_data_reg;

    logic        accept;
    logic        take;
    bgd_result_t new_result;

    logic                 sess;
    logic [ElapsedW-1:0]  d;
    logic signed [LevelW+1:0] stepped;
    logic signed [LevelW+1:0] max_s;
    logic signed [LevelW+1:0] min_s;
    logic [RampW-1:0]     ramp_eff;

    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !skid_valid_reg;
    assign take         = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // dimming step candidate
    assign max_s    = $signed({2'b00, cfg.max_level});
    assign min_s    = $signed({2'b00, cfg.min_level});
    assign stepped  = going_down_reg
                    ? $signed({2'b00, level_reg}) - $signed({5'b00000, cfg.step_size})
                    : $signed({2'b00, level_reg}) + $signed({5'b00000, cfg.step_size});
    assign ramp_eff = (cfg.ramp_ticks == '0) ? RampW'(1) : cfg.ramp_ticks;

    // per-tick gesture logic
    always_comb
    begin
        in_session_next  = in_session_reg;
        elapsed_next     = elapsed_reg;
        mode_on_next     = mode_on_reg;
        level_next       = level_reg;
        going_down_next  = going_down_reg;
        ramp_wait_next   = ramp_wait_reg;
        drive_level_next = drive_level_reg;
        wrote            = 1'b0;

        sess = in_session_reg || item.press_event;
        d    = in_session_reg ? elapsed_reg : '0;
        in_session_next = sess;

        if (sess)
        begin
            if (ramp_wait_reg != '0)
            begin
                ramp_wait_next = ramp_wait_reg - RampW'(1);
            end
            else if (d < {{(ElapsedW-DebounceW){1'b0}}, cfg.debounce_ticks})
            begin
                // debounce window
            end
            else if (item.button_level)
            begin
                if (d > cfg.hold_ticks)
                begin
                    mode_on_next = 1'b1;
                    if (stepped >= max_s)
                    begin
                        level_next      = cfg.max_level;
                        going_down_next = 1'b1;
                    end
                    else if (stepped <= min_s)
                    begin
                        level_next      = cfg.min_level;
                        going_down_next = 1'b0;
                    end
                    else
                    begin
                        level_next = stepped[LevelW-1:0];
                    end
                    drive_level_next = level_next;
                    wrote            = 1'b1;
                    ramp_wait_next   = ramp_eff - RampW'(1);
                end
            end
            else
            begin
                in_session_next = 1'b0;
                if (d < cfg.hold_ticks)
                begin
                    if (mode_on_reg)
                    begin
                        mode_on_next     = 1'b0;
                        drive_level_next = '0;
                    end
                    else
                    begin
                        mode_on_next = 1'b1;
                        if (level_reg < cfg.min_level)
                        begin
                            level_next = cfg.max_level;
                        end
                        drive_level_next = level_next;
                    end
                    wrote = 1'b1;
                end
                else
                begin
                    going_down_next = !going_down_reg;
                end
            end

            // elapsed counter saturates at its top
            if (in_session_next && d != ElapsedTop)
            begin
                elapsed_next = d + ElapsedW'(1);
            end
            else
            begin
                elapsed_next = d;
            end
        end

        new_result.lamp_on       = mode_on_next;
        new_result.pwm_level     = drive_level_next;
        new_result.level_written = wrote;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_session_reg  <= 1'b0;
            elapsed_reg     <= '0;
            mode_on_reg     <= 1'b0;
            level_reg       <= '0;
            going_down_reg  <= 1'b0;
            ramp_wait_reg   <= '0;
            drive_level_reg <= '0;
        end
        else if (accept)
        begin
            in_session_reg  <= in_session_next;
            elapsed_reg     <= elapsed_next;
            mode_on_reg     <= mode_on_next;
            level_reg       <= level_next;
            going_down_reg  <= going_down_next;
            ramp_wait_reg   <= ramp_wait_next;
            drive_level_reg <= drive_level_next;
        end
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output buffer data
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_reg <= new_result;
            end
            else
            begin
                out_data_reg <= new_result;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // skid entry is only used behind a full result register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while result register empty");

    // an accepted item always shows up as a pending result
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("accepted item produced no result");

    // no stall toward the sender while the output side is empty
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item stalled with empty output buffer");

    // a lamp that is off drives zero brightness
    a_off_means_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.lamp_on) |-> (result.pwm_level == '0))
        else $error("nonzero pwm level while lamp off");
`endif

endmodule
